// ===== hw/rtl/nle_pkg.sv =====
`default_nettype none
package nle_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned OrderW = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CoefW  = 32;

  // 1.0 in signed Q8.24
  localparam logic signed [ValW-1:0] OneQ24 = 32'sh0100_0000;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  typedef enum logic [0:0] {
    RegDomainMin = 1'b0,
    RegNormScale = 1'b1
  } nle_reg_e;

  // Work item handed from cell to cell along the recurrence chain
  typedef struct packed {
    logic                     vld;
    logic [OrderW-1:0]        n;
    logic                     sat;
    logic signed [ValW-1:0]   z;
    logic signed [ValW-1:0]   p0;
    logic signed [ValW-1:0]   p1;
  } nle_tok_t;

  // round(sqrt((2n+1)/2) * 2^28), bitwise integer root; elaboration only
  function automatic logic [31:0] norm_q28(input int unsigned n);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    int          k;
    x  = 64'(2 * n + 1) << 55;
    r  = '0;
    bt = 64'(1) << 62;
    for (k = 0; k < 32; k++) begin
      if (bt > x) begin
        bt = bt >> 2;
      end
    end
    for (k = 0; k < 32; k++) begin
      if (bt != '0) begin
        if (x >= r + bt) begin
          x = x - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    if (x > r) begin
      r = r + 64'd1;
    end
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nle_zmap.sv =====
`default_nettype none
module nle_zmap #(
  parameter int unsigned MAX_ORDER = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  logic [nle_pkg::PosW-1:0]          position_i,
  input  logic [nle_pkg::OrderW-1:0]        order_i,
  input  logic [nle_pkg::PosW-1:0]          domain_min_i,
  input  logic [nle_pkg::PosW-1:0]          norm_scale_i,
  output nle_pkg::nle_tok_t                 tok_o
);
  import nle_pkg::*;

  localparam logic [6:0] MaxOrderV = 7'(MAX_ORDER);
  localparam logic signed [58:0] ZOffPos = -59'sd16777216;
  localparam logic signed [58:0] ZOffNeg = -59'sd16777215;

  // stage A: difference and order clamp
  logic                    vld_a_q;
  logic [OrderW-1:0]       n_a_q, n_a_d;
  logic signed [PosW:0]    d_a_q, d_a_d;

  // stage B: magnitude times scale
  logic                    vld_b_q;
  logic [OrderW-1:0]       n_b_q;
  logic                    neg_b_q;
  logic [PosW:0]           mag_b;
  logic [64:0]             prod_b_full;
  logic [63:0]             prod_b_q;

  // stage C: round, sign, offset, clamp
  logic [64:0]             rsum_c;
  logic [56:0]             q_c;
  logic signed [58:0]      zop_c, z_full_c;
  logic                    hi_c, lo_c, zsat_c;
  logic signed [ValW-1:0]  z_c;
  nle_tok_t                tok_q, tok_d;

  always_comb begin
    d_a_d = $signed({position_i[PosW-1], position_i})
          - $signed({domain_min_i[PosW-1], domain_min_i});
    if (7'(order_i) > MaxOrderV) begin
      n_a_d = OrderW'(MAX_ORDER);
    end else begin
      n_a_d = order_i;
    end
  end

  always_comb begin
    mag_b       = d_a_q[PosW] ? (PosW+1)'(-d_a_q) : (PosW+1)'(d_a_q);
    prod_b_full = {32'd0, mag_b} * {33'd0, norm_scale_i};
  end

  always_comb begin
    rsum_c = {1'b0, prod_b_q} + 65'd128;
    q_c    = rsum_c[64:8];
    // negate as invert plus one, folded into the offset
    zop_c    = neg_b_q ? ~$signed({2'b00, q_c}) : $signed({2'b00, q_c});
    z_full_c = zop_c + (neg_b_q ? ZOffNeg : ZOffPos);
    hi_c     = !z_full_c[58] && (|z_full_c[57:31]);
    lo_c     = z_full_c[58] && !(&z_full_c[57:31]);
    zsat_c   = hi_c || lo_c;
    if (hi_c) begin
      z_c = ValMax;
    end else if (lo_c) begin
      z_c = ValMin;
    end else begin
      z_c = z_full_c[31:0];
    end
    tok_d.vld = vld_b_q;
    tok_d.n   = n_b_q;
    tok_d.z   = z_c;
    tok_d.p0  = OneQ24;
    if (n_b_q == '0) begin
      tok_d.p1  = OneQ24;
      tok_d.sat = 1'b0;
    end else begin
      tok_d.p1  = z_c;
      tok_d.sat = zsat_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      tok_q   <= '0;
    end else if (adv_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n_a_q    <= n_a_d;
      d_a_q    <= d_a_d;
      n_b_q    <= n_a_q;
      neg_b_q  <= d_a_q[PosW];
      prod_b_q <= prod_b_full[63:0];
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ===== hw/rtl/nle_cell.sv =====
`default_nettype none
module nle_cell #(
  parameter int unsigned Idx = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  nle_pkg::nle_tok_t  tok_i,
  output nle_pkg::nle_tok_t  tok_o
);
  import nle_pkg::*;

  // (2i-1)/i and (i-1)/i in Q2.30, rounded to nearest
  localparam logic [63:0] CoefA64 = ((64'(2 * Idx - 1) << 31) + 64'(Idx)) / (64'(Idx) << 1);
  localparam logic [63:0] CoefB64 = ((64'(Idx - 1) << 31) + 64'(Idx)) / (64'(Idx) << 1);
  localparam logic signed [CoefW-1:0] CoefA = CoefA64[CoefW-1:0];
  localparam logic signed [CoefW-1:0] CoefB = CoefB64[CoefW-1:0];
  localparam logic [6:0] IdxV = 7'(Idx);

  // stage 1: coefficient products
  nle_tok_t            tok1_q;
  logic                act1_q;
  logic signed [63:0]  pa_q, pa_d, pb_q, pb_d;

  // stage 2: round t and v, t times z
  nle_tok_t            tok2_q;
  logic                act2_q;
  logic signed [63:0]  rsa, rsb;
  logic signed [33:0]  t2, v2;
  logic signed [65:0]  u_q, u_d;
  logic signed [33:0]  v_q;

  // stage 3: round u, subtract, clamp
  logic signed [65:0]  rsu;
  logic signed [41:0]  u3;
  logic signed [42:0]  diff3;
  logic                hi3, lo3;
  logic signed [ValW-1:0] p3;
  nle_tok_t            tok3_q, tok3_d;

  always_comb begin
    pa_d = $signed(tok_i.p1) * CoefA;
    pb_d = $signed(tok_i.p0) * CoefB;
  end

  always_comb begin
    // ties away from zero: add half, less one when negative, then shift
    rsa = pa_q + (pa_q[63] ? 64'sh1FFF_FFFF : 64'sh2000_0000);
    rsb = pb_q + (pb_q[63] ? 64'sh1FFF_FFFF : 64'sh2000_0000);
    t2  = rsa[63:30];
    v2  = rsb[63:30];
    u_d = t2 * $signed(tok1_q.z);
  end

  always_comb begin
    rsu   = u_q + (u_q[65] ? 66'sh7F_FFFF : 66'sh80_0000);
    u3    = rsu[65:24];
    diff3 = $signed({u3[41], u3}) - $signed({{9{v_q[33]}}, v_q});
    hi3   = !diff3[42] && (|diff3[41:31]);
    lo3   = diff3[42] && !(&diff3[41:31]);
    if (hi3) begin
      p3 = ValMax;
    end else if (lo3) begin
      p3 = ValMin;
    end else begin
      p3 = diff3[31:0];
    end
    tok3_d = tok2_q;
    if (act2_q) begin
      tok3_d.p0  = tok2_q.p1;
      tok3_d.p1  = p3;
      tok3_d.sat = tok2_q.sat || hi3 || lo3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
      tok3_q <= '0;
    end else if (adv_i) begin
      tok1_q <= tok_i;
      tok2_q <= tok1_q;
      tok3_q <= tok3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      act1_q <= (7'(tok_i.n) >= IdxV);
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      act2_q <= act1_q;
      u_q    <= u_d;
      v_q    <= v2;
    end
  end

  assign tok_o = tok3_q;

endmodule
`default_nettype wire

// ===== hw/rtl/nle_scale.sv =====
`default_nettype none
module nle_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  nle_pkg::nle_tok_t            tok_i,
  output logic                         vld_o,
  output logic [nle_pkg::ValW-1:0]     value_o,
  output logic                         sat_o
);
  import nle_pkg::*;

  localparam int unsigned NormDepth = 2 ** OrderW;

  logic [31:0]         norm_rom [NormDepth];

  for (genvar k = 0; k < NormDepth; k++) begin : g_rom
    assign norm_rom[k] = norm_q28(k);
  end

  logic                vld1_q;
  logic                sat1_q;
  logic signed [64:0]  pm_q, pm_d;
  logic signed [64:0]  rs;
  logic signed [36:0]  r2;
  logic                hi2, lo2;
  logic [ValW-1:0]     val_d;
  logic                vld_q, sat_q;
  logic [ValW-1:0]     val_q;

  always_comb begin
    pm_d = $signed(tok_i.p1) * $signed({1'b0, norm_rom[tok_i.n]});
  end

  always_comb begin
    rs  = pm_q + (pm_q[64] ? 65'sh7FF_FFFF : 65'sh800_0000);
    r2  = rs[64:28];
    hi2 = !r2[36] && (|r2[35:31]);
    lo2 = r2[36] && !(&r2[35:31]);
    if (hi2) begin
      val_d = ValMax;
    end else if (lo2) begin
      val_d = ValMin;
    end else begin
      val_d = r2[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld_q  <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= tok_i.vld;
      vld_q  <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pm_q   <= pm_d;
      sat1_q <= tok_i.sat;
      val_q  <= val_d;
      sat_q  <= sat1_q || hi2 || lo2;
    end
  end

  assign vld_o   = vld_q;
  assign value_o = val_q;
  assign sat_o   = sat_q;

endmodule
`default_nettype wire

// ===== hw/rtl/normalized_legendre_eval.sv =====
`default_nettype none
// Orthonormal Legendre evaluator. Each request carries a Q16.16 position and
// an order n; the block maps the position to z = (position - domain_min) *
// norm_scale - 1, runs the three-term recurrence up to n and scales the result
// by sqrt((2n+1)/2), returning a saturated Q8.24 value plus a sticky flag in
// tuser. The recurrence is a chain of MAX_ORDER-1 cells that differ only in
// their coefficients, one per step, each three registers deep; cells above
// the requested order pass the item through. One request is taken per clock
// unless the output stalls: the whole chain holds while the output register
// is full and not taken. Write domain_min and norm_scale only while no
// request is in flight.
module normalized_legendre_eval #(
  parameter int unsigned MAX_ORDER = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] position, [36:32] order, rest zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] poly_value
  output logic        m_axis_tuser_o    // [0] saturated
);
  import nle_pkg::*;

  localparam int unsigned NumCells = MAX_ORDER - 1;

  logic            adv;
  logic [PosW-1:0] dmin_q, scale_q;
  nle_tok_t        tok [MAX_ORDER];

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q  <= '0;
      scale_q <= 32'd131072;
    end else if (cfg_we_i) begin
      case (nle_reg_e'(cfg_idx_i))
        RegDomainMin: dmin_q  <= cfg_wdata_i;
        RegNormScale: scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  nle_zmap #(
    .MAX_ORDER(MAX_ORDER)
  ) u_zmap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .vld_i        (s_axis_tvalid_i),
    .position_i   (s_axis_tdata_i[31:0]),
    .order_i      (s_axis_tdata_i[36:32]),
    .domain_min_i (dmin_q),
    .norm_scale_i (scale_q),
    .tok_o        (tok[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    nle_cell #(
      .Idx(k + 2)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  nle_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tok_i   (tok[MAX_ORDER-1]),
    .vld_o   (m_axis_tvalid_o),
    .value_o (m_axis_tdata_o),
    .sat_o   (m_axis_tuser_o)
  );

`ifndef SYNTH
  // a stalled output must hold the whole chain, input side included
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input open while output stalled");

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(tok[0]))
    else $error("chain moved during stall");

  a_stall_holds_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(tok[MAX_ORDER-1]))
    else $error("chain tail moved during stall");

  a_reset_no_result: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");
`endif

endmodule
`default_nettype wire
